>>> rtl/conv3x3_normalized_filter_macros.svh
// Assertion macros for the 3x3 normalized filter checker.
// Depends on signals named clk and rst_n in the scope where a macro is used.
`ifndef CONV3X3_NORMALIZED_FILTER_MACROS_SVH
`define CONV3X3_NORMALIZED_FILTER_MACROS_SVH

// check while out of reset
`define C3NF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define C3NF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/c3nf_pkg.sv
// Shared types and constants of the 3x3 normalized convolution filter.
// No dependencies.
package c3nf_pkg;

    localparam int COEF_BITS     = 7;
    localparam int NUM_TAPS      = 9;
    localparam int CHAN_BITS     = 8;
    localparam int PIX_BITS      = 3 * CHAN_BITS;
    localparam int KERNEL_BITS   = NUM_TAPS * COEF_BITS;
    localparam int GEOM_BITS     = 11;
    localparam int SUM_BITS      = 19;
    localparam int NUM_BITS      = 18;
    localparam int DIV_BITS      = 10;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int MIN_GEOM      = 3;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLOR  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd3;

    localparam logic [KERNEL_BITS-1:0] KERNEL_RESET = 63'd268435456;
    localparam logic [GEOM_BITS-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [GEOM_BITS-1:0]   HEIGHT_RESET = 11'd480;

    typedef logic [PIX_BITS-1:0]  pix_t;
    typedef logic [CHAN_BITS-1:0] chan_t;

    function automatic logic signed [COEF_BITS-1:0] coef_at(
        input logic [KERNEL_BITS-1:0] kernel,
        input logic [3:0]             k
    );
        return kernel[COEF_BITS*k +: COEF_BITS];
    endfunction

endpackage

>>> rtl/c3nf_pix_if.sv
// Input pixel channel of the 3x3 normalized filter.
// Depends on c3nf_pkg.
interface c3nf_pix_if;
    logic                  valid;
    logic                  ready;
    c3nf_pkg::chan_t       pixel_c0;
    c3nf_pkg::chan_t       pixel_c1;
    c3nf_pkg::chan_t       pixel_c2;
    logic                  flush;

    modport source (output valid, pixel_c0, pixel_c1, pixel_c2, flush, input ready);
    modport sink   (input valid, pixel_c0, pixel_c1, pixel_c2, flush, output ready);
endinterface

>>> rtl/c3nf_res_if.sv
// Result channel of the 3x3 normalized filter.
// Depends on c3nf_pkg.
interface c3nf_res_if;
    logic                  valid;
    logic                  ready;
    c3nf_pkg::chan_t       out_c0;
    c3nf_pkg::chan_t       out_c1;
    c3nf_pkg::chan_t       out_c2;
    logic                  frame_last;

    modport source (output valid, out_c0, out_c1, out_c2, frame_last, input ready);
    modport sink   (input valid, out_c0, out_c1, out_c2, frame_last, output ready);
endinterface

>>> rtl/c3nf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module c3nf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/conv3x3_normalized_filter.sv
// 3x3 normalized convolution filter over a raster pixel stream: top level.
// Depends on c3nf_pkg, c3nf_pix_if, c3nf_res_if and c3nf_ram.
//
// Pixels enter in raster order; the result for pixel (r,c) leaves after the pixel at (r+1,c+1)
// is taken, so a frame needs W*H pixel transactions and W+1 flush transactions. One pixel at a
// time is processed. A transaction that yields no result is accepted, then reads the line
// memory and writes it back. One that yields a result then goes through, per filtered channel
// (one in gray mode, three in color mode), a multiply-accumulate pass and a division: a shared
// 7x8 multiplier accumulates the nine taps, then a restoring divider makes one quotient bit per
// cycle; a negative sum or all-zero kernel skips the divider. The two previous lines live in one
// MAX_WIDTH x 48 memory with registered read; it has no clearing pass. A new pixel can be
// taken while a finished result waits in the output register. Writing the width or height
// restarts the frame.
module conv3x3_normalized_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [c3nf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [c3nf_pkg::KERNEL_BITS-1:0]      cfg_data,
    c3nf_pix_if.sink                              pixel,
    c3nf_res_if.source                            result
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int GB = c3nf_pkg::GEOM_BITS;
    localparam int PB = c3nf_pkg::PIX_BITS;
    localparam int COEF_W = c3nf_pkg::COEF_BITS;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_DIV, S_DONE} state_t;

    state_t                                   state_reg;
    logic [c3nf_pkg::KERNEL_BITS-1:0]         kernel_reg;
    logic                                     gray_reg;
    logic [GB-1:0]                            width_reg;
    logic [GB-1:0]                            height_reg;
    logic [CW-1:0]                            col_reg;
    logic [GB-1:0]                            row_reg;
    logic [CW-1:0]                            cur_col_reg;
    c3nf_pkg::pix_t                           pix_reg;
    c3nf_pkg::pix_t                           win_reg [9];
    c3nf_pkg::pix_t                           nb_reg [9];
    logic [3:0]                               tap_reg;
    logic [1:0]                               ch_reg;
    logic signed [c3nf_pkg::SUM_BITS-1:0]     acc_reg;
    logic [c3nf_pkg::DIV_BITS-1:0]            dv_reg;
    logic [c3nf_pkg::NUM_BITS-1:0]            num_reg;
    logic [c3nf_pkg::NUM_BITS-1:0]            quo_reg;
    logic [c3nf_pkg::DIV_BITS-1:0]            rem_reg;
    logic [4:0]                               step_reg;
    c3nf_pkg::chan_t                          res_reg [3];
    logic                                     last_reg;
    logic                                     out_valid_reg;
    c3nf_pkg::chan_t                          out_c0_reg;
    c3nf_pkg::chan_t                          out_c1_reg;
    c3nf_pkg::chan_t                          out_c2_reg;
    logic                                     out_last_reg;

    logic [CW-1:0]                            w;
    logic [GB-1:0]                            h;
    logic [CW-1:0]                            c_eff;
    logic [CW-1:0]                            c_inc;
    logic [2*PB-1:0]                          ram_rdata;
    logic [2*PB-1:0]                          ram_wdata;
    c3nf_pkg::pix_t                           above;
    c3nf_pkg::pix_t                           above2;
    c3nf_pkg::pix_t                           newcol [3];
    logic                                     emit;
    logic                                     last;
    logic                                     top0;
    logic                                     bot0;
    logic                                     left0;
    logic                                     right_in;
    logic signed [COEF_W-1:0]                 coef;
    logic [COEF_W-1:0]                        coef_abs;
    logic signed [15:0]                       prod;
    logic signed [c3nf_pkg::SUM_BITS-1:0]     acc_sum;
    logic [c3nf_pkg::DIV_BITS-1:0]            dv_sum;
    logic [c3nf_pkg::DIV_BITS:0]              rem_shift;
    logic                                     rem_ge;
    logic [c3nf_pkg::NUM_BITS-1:0]            quo_new;
    c3nf_pkg::chan_t                          quo_sat;
    logic                                     accept;

    always_comb
    begin
        if (width_reg < GB'(c3nf_pkg::MIN_GEOM))
            w = CW'(c3nf_pkg::MIN_GEOM);
        else if (32'(width_reg) > MAX_WIDTH)
            w = CW'(MAX_WIDTH);
        else
            w = CW'(width_reg);
        if (height_reg < GB'(c3nf_pkg::MIN_GEOM))
            h = GB'(c3nf_pkg::MIN_GEOM);
        else if (height_reg > GB'(c3nf_pkg::HEIGHT_LIMIT))
            h = GB'(c3nf_pkg::HEIGHT_LIMIT);
        else
            h = height_reg;
    end

    assign c_eff  = (col_reg >= w) ? '0 : col_reg;
    assign c_inc  = cur_col_reg + CW'(1);
    assign accept = pixel.valid && pixel.ready;
    assign pixel.ready = (state_reg == S_IDLE);

    assign above     = ram_rdata[PB-1:0];
    assign above2    = ram_rdata[2*PB-1:PB];
    assign newcol[0] = above2;
    assign newcol[1] = above;
    assign newcol[2] = pix_reg;
    assign ram_wdata = {above, pix_reg};

    c3nf_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (state_reg == S_READ),
        .waddr (cur_col_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (c_eff[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        emit     = 1'b0;
        last     = 1'b0;
        top0     = 1'b0;
        bot0     = 1'b0;
        left0    = 1'b0;
        right_in = 1'b0;
        if (cur_col_reg != '0 && row_reg != '0)
        begin
            emit     = 1'b1;
            right_in = 1'b1;
            top0     = (row_reg == GB'(1));
            bot0     = (row_reg >= h);
            left0    = (cur_col_reg == CW'(1));
        end
        else if (cur_col_reg == '0 && row_reg >= GB'(2))
        begin
            emit = 1'b1;
            top0 = (row_reg == GB'(2));
            bot0 = (row_reg >= h + GB'(1));
            last = (row_reg == h + GB'(1));
        end
    end

    always_comb
    begin
        coef      = c3nf_pkg::coef_at(kernel_reg, tap_reg);
        coef_abs  = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);
        prod      = 16'(coef) * $signed({8'd0, nb_reg[tap_reg][8*ch_reg +: 8]});
        acc_sum   = acc_reg + c3nf_pkg::SUM_BITS'(prod);
        dv_sum    = dv_reg + c3nf_pkg::DIV_BITS'(coef_abs);
        rem_shift = {rem_reg, num_reg[c3nf_pkg::NUM_BITS-1]};
        rem_ge    = rem_shift >= {1'b0, dv_reg};
        quo_new   = {quo_reg[c3nf_pkg::NUM_BITS-2:0], rem_ge};
        quo_sat   = (quo_new > c3nf_pkg::NUM_BITS'(255)) ? 8'd255 : quo_new[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kernel_reg    <= c3nf_pkg::KERNEL_RESET;
            gray_reg      <= 1'b0;
            width_reg     <= c3nf_pkg::WIDTH_RESET;
            height_reg    <= c3nf_pkg::HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (result.valid && result.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    c3nf_pkg::REG_KERNEL: kernel_reg <= cfg_data;
                    c3nf_pkg::REG_COLOR:  gray_reg   <= cfg_data[0];
                    c3nf_pkg::REG_WIDTH,
                    c3nf_pkg::REG_HEIGHT:
                    begin
                        if (cfg_index == c3nf_pkg::REG_WIDTH)
                            width_reg <= cfg_data[GB-1:0];
                        else
                            height_reg <= cfg_data[GB-1:0];
                        col_reg <= '0;
                        row_reg <= '0;
                        for (int i = 0; i < 9; i++)
                            win_reg[i] <= '0;
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_col_reg <= c_eff;
                        if (pixel.flush || row_reg >= h)
                            pix_reg <= '0;
                        else
                            pix_reg <= {pixel.pixel_c2, pixel.pixel_c1, pixel.pixel_c0};
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        nb_reg[i]     <= (top0 && i == 0) || (bot0 && i == 2) || left0
                                         ? '0 : win_reg[3*i+1];
                        nb_reg[i + 3] <= (top0 && i == 0) || (bot0 && i == 2)
                                         ? '0 : win_reg[3*i+2];
                        nb_reg[i + 6] <= (top0 && i == 0) || (bot0 && i == 2) || !right_in
                                         ? '0 : newcol[i];
                        win_reg[3*i]   <= win_reg[3*i+1];
                        win_reg[3*i+1] <= win_reg[3*i+2];
                        win_reg[3*i+2] <= newcol[i];
                    end
                    if (c_inc >= w)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + GB'(1);
                    end
                    else
                    begin
                        col_reg <= c_inc;
                    end
                    last_reg <= last;
                    for (int i = 0; i < 3; i++)
                        res_reg[i] <= '0;
                    tap_reg <= '0;
                    ch_reg  <= '0;
                    acc_reg <= '0;
                    dv_reg  <= '0;
                    state_reg <= emit ? S_MAC : S_IDLE;
                end
                S_MAC:
                begin
                    if (tap_reg == 4'(c3nf_pkg::NUM_TAPS - 1))
                    begin
                        num_reg  <= acc_sum[c3nf_pkg::NUM_BITS-1:0];
                        quo_reg  <= '0;
                        rem_reg  <= '0;
                        step_reg <= '0;
                        if (acc_sum < 0 || dv_sum == '0)
                        begin
                            res_reg[ch_reg] <= '0;
                            tap_reg <= '0;
                            acc_reg <= '0;
                            dv_reg  <= '0;
                            if (gray_reg || ch_reg == 2'd2)
                                state_reg <= S_DONE;
                            else
                                ch_reg <= ch_reg + 2'd1;
                        end
                        else
                        begin
                            dv_reg    <= dv_sum;
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        dv_reg  <= dv_sum;
                        tap_reg <= tap_reg + 4'd1;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= rem_ge ? c3nf_pkg::DIV_BITS'(rem_shift - {1'b0, dv_reg})
                                       : rem_shift[c3nf_pkg::DIV_BITS-1:0];
                    quo_reg  <= quo_new;
                    num_reg  <= {num_reg[c3nf_pkg::NUM_BITS-2:0], 1'b0};
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(c3nf_pkg::NUM_BITS - 1))
                    begin
                        res_reg[ch_reg] <= quo_sat;
                        tap_reg <= '0;
                        acc_reg <= '0;
                        dv_reg  <= '0;
                        if (gray_reg || ch_reg == 2'd2)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_c0_reg    <= res_reg[0];
                        out_c1_reg    <= res_reg[1];
                        out_c2_reg    <= res_reg[2];
                        out_last_reg  <= last_reg;
                        if (last_reg)
                        begin
                            col_reg <= '0;
                            row_reg <= '0;
                            for (int i = 0; i < 9; i++)
                                win_reg[i] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_c0     = out_c0_reg;
    assign result.out_c1     = out_c1_reg;
    assign result.out_c2     = out_c2_reg;
    assign result.frame_last = out_last_reg;

endmodule

>>> rtl/c3nf_checker.sv
// Port-level checks of the 3x3 normalized filter, bound to the top level.
// Depends on conv3x3_normalized_filter_macros.svh.
`include "conv3x3_normalized_filter_macros.svh"

module c3nf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_c0,
    input logic [7:0] out_c1,
    input logic [7:0] out_c2,
    input logic       out_last
);

    `C3NF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `C3NF_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_c0, out_c1, out_c2, out_last}), "result changed while stalled")
    `C3NF_ASSERT(a_no_fast_result, in_valid && in_ready |=> !$rose(out_valid), "result appeared one cycle after a transaction")
    `C3NF_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind conv3x3_normalized_filter c3nf_checker u_c3nf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_c0    (result.out_c0),
    .out_c1    (result.out_c1),
    .out_c2    (result.out_c2),
    .out_last  (result.frame_last)
);

>>> tb/tb.sv
// Self-checking testbench for conv3x3_normalized_filter: drives pixel frames and
// register settings, predicts every filtered pixel and compares each result transaction.
// Depends on c3nf_pkg, c3nf_pix_if, c3nf_res_if and the filter RTL.
module tb;

    localparam int WIDTH_CAP   = 1024;
    localparam int WATCH_LIMIT = 4000;
    localparam int SETTLE      = 150;

    typedef struct packed {
        c3nf_pkg::chan_t c0;
        c3nf_pkg::chan_t c1;
        c3nf_pkg::chan_t c2;
        logic            flush;
    } pixel_item_t;

    typedef struct packed {
        c3nf_pkg::chan_t o0;
        c3nf_pkg::chan_t o1;
        c3nf_pkg::chan_t o2;
        logic            last;
    } filtered_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic cfg_we;
    logic [c3nf_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [c3nf_pkg::KERNEL_BITS-1:0]  cfg_data;

    c3nf_pix_if pix ();
    c3nf_res_if res ();

    conv3x3_normalized_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix.sink),
        .result    (res.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // filter state mirror
    logic [c3nf_pkg::KERNEL_BITS-1:0] kernel;
    logic                             gray;
    logic [c3nf_pkg::GEOM_BITS-1:0]   width_reg;
    logic [c3nf_pkg::GEOM_BITS-1:0]   height_reg;
    c3nf_pkg::pix_t                   line_mem [0:2*WIDTH_CAP-1];
    c3nf_pkg::pix_t                   win [0:8];
    c3nf_pkg::pix_t                   nb [0:8];
    int                               col_pos;
    int                               row_pos;

    pixel_item_t pending [$];
    filtered_t   expected [$];
    int          errors;
    int          checked;
    int          items_pushed;
    int          frames_sent;
    bit          quiet;
    int          idle_cycles;

    function automatic int coef(input int k);
        logic signed [c3nf_pkg::COEF_BITS-1:0] c;
        c = kernel[c3nf_pkg::COEF_BITS*k +: c3nf_pkg::COEF_BITS];
        return int'(c);
    endfunction

    function automatic c3nf_pkg::chan_t filter_chan(input int ch);
        int acc;
        int divisor;
        int c;
        divisor = 0;
        acc = 0;
        for (int k = 0; k < 9; k++)
        begin
            c = coef(k);
            divisor += (c < 0) ? -c : c;
        end
        if (divisor == 0)
            return '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                acc += coef(i + 3 * j) * int'({24'd0, nb[i*3+j][8*ch +: 8]});
        acc = acc / divisor;
        if (acc < 0)
            return '0;
        if (acc > 255)
            return 8'd255;
        return c3nf_pkg::chan_t'(acc);
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 9; i++)
            win[i] = '0;
    endfunction

    function automatic int clamp_geom(input int v, input int hi);
        return (v < c3nf_pkg::MIN_GEOM) ? c3nf_pkg::MIN_GEOM : ((v > hi) ? hi : v);
    endfunction

    function automatic bit filter_pixel(input pixel_item_t it, output filtered_t f);
        int w, h, r, c;
        c3nf_pkg::pix_t p, above, above2;
        c3nf_pkg::pix_t ncol [0:2];
        bit emit, last, top0, bot0, left0;
        w = clamp_geom(int'(width_reg), WIDTH_CAP);
        h = clamp_geom(int'(height_reg), c3nf_pkg::HEIGHT_LIMIT);
        r = row_pos;
        c = col_pos;
        emit = 0; last = 0; top0 = 0; bot0 = 0; left0 = 0;
        f = '0;
        if (c >= w)
            c = 0;
        p = (it.flush || r >= h) ? '0 : {it.c2, it.c1, it.c0};
        above = line_mem[c];
        above2 = line_mem[WIDTH_CAP + c];
        line_mem[WIDTH_CAP + c] = above;
        line_mem[c] = p;
        ncol[0] = above2;
        ncol[1] = above;
        ncol[2] = p;
        for (int i = 0; i < 3; i++)
        begin
            nb[i*3]   = win[i*3+1];
            nb[i*3+1] = win[i*3+2];
            nb[i*3+2] = '0;
        end
        if (c >= 1 && r >= 1)
        begin
            for (int i = 0; i < 3; i++)
                nb[i*3+2] = ncol[i];
            emit = 1;
            top0 = (r == 1);
            bot0 = (r >= h);
            left0 = (c == 1);
        end
        else if (c == 0 && r >= 2)
        begin
            emit = 1;
            top0 = (r == 2);
            bot0 = (r - 1 >= h);
            last = (r == h + 1);
        end
        for (int j = 0; j < 3; j++)
        begin
            if (top0)
                nb[j] = '0;
            if (bot0)
                nb[6+j] = '0;
            if (left0)
                nb[j*3] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
            win[i*3+2] = ncol[i];
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        if (!emit)
            return 0;
        f.o0 = filter_chan(0);
        f.o1 = gray ? '0 : filter_chan(1);
        f.o2 = gray ? '0 : filter_chan(2);
        f.last = last;
        if (last)
            restart_frame();
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // pixel driver
    int          src_gap;
    pixel_item_t src_next;
    filtered_t   src_pred;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix.valid <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (filter_pixel({pix.pixel_c0, pix.pixel_c1, pix.pixel_c2, pix.flush},
                                 src_pred))
                    expected.push_back(src_pred);
            end
            if (!pix.valid || pix.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    pix.valid <= 1'b0;
                end
                else if (pending.size() > 0 && (quiet || $urandom_range(0, 7) != 0))
                begin
                    src_next = pending.pop_front();
                    pix.pixel_c0 <= src_next.c0;
                    pix.pixel_c1 <= src_next.c1;
                    pix.pixel_c2 <= src_next.c2;
                    pix.flush <= src_next.flush;
                    pix.valid <= 1'b1;
                end
                else
                begin
                    if (pending.size() > 0)
                        src_gap <= $urandom_range(0, 2);
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int        sink_gap;
    filtered_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected.size() == 0)
                    report_mismatch("unexpected result transaction", 1, 0);
                else
                begin
                    want = expected.pop_front();
                    checked++;
                    if (res.out_c0 !== want.o0)
                        report_mismatch("out_c0", res.out_c0, want.o0);
                    if (res.out_c1 !== want.o1)
                        report_mismatch("out_c1", res.out_c1, want.o1);
                    if (res.out_c2 !== want.o2)
                        report_mismatch("out_c2", res.out_c2, want.o2);
                    if (res.frame_last !== want.last)
                        report_mismatch("frame_last", res.frame_last, want.last);
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                res.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                sink_gap <= $urandom_range(0, 2);
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", expected.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [c3nf_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [c3nf_pkg::KERNEL_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            c3nf_pkg::REG_KERNEL: kernel = data;
            c3nf_pkg::REG_COLOR:  gray = data[0];
            c3nf_pkg::REG_WIDTH:
            begin
                width_reg = data[c3nf_pkg::GEOM_BITS-1:0];
                restart_frame();
            end
            default:
            begin
                height_reg = data[c3nf_pkg::GEOM_BITS-1:0];
                restart_frame();
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input int c0, input int c1, input int c2, input bit fl);
        pixel_item_t it;
        it.c0 = c3nf_pkg::chan_t'(c0);
        it.c1 = c3nf_pkg::chan_t'(c1);
        it.c2 = c3nf_pkg::chan_t'(c2);
        it.flush = fl;
        pending.push_back(it);
        items_pushed++;
    endtask

    task automatic push_random_pixel(input bit allow_flush);
        push_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   allow_flush && $urandom_range(0, 15) == 0);
    endtask

    // a whole frame, or only its first count items when count is positive
    task automatic push_frame(input int count);
        int w, h, n;
        w = clamp_geom(int'(width_reg), WIDTH_CAP);
        h = clamp_geom(int'(height_reg), c3nf_pkg::HEIGHT_LIMIT);
        n = (count > 0) ? count : w * h;
        for (int i = 0; i < n; i++)
            push_random_pixel(1'b1);
        if (count == 0)
        begin
            for (int i = 0; i <= w; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_random_pixel(1'b0);
                else
                    push_pixel(0, 0, 0, 1'b1);
            end
            frames_sent++;
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending.size() != 0 || pix.valid || expected.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [c3nf_pkg::KERNEL_BITS-1:0] random_kernel();
        logic [c3nf_pkg::KERNEL_BITS-1:0] k;
        k = c3nf_pkg::KERNEL_BITS'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: for (int i = 0; i < 9; i++)
                   k[c3nf_pkg::COEF_BITS*i +: c3nf_pkg::COEF_BITS] =
                       c3nf_pkg::COEF_BITS'($urandom_range(0, 4));
            1: for (int i = 0; i < 9; i++)
                   if ($urandom_range(0, 1) == 0)
                       k[c3nf_pkg::COEF_BITS*i +: c3nf_pkg::COEF_BITS] = '0;
            default: ;
        endcase
        return k;
    endfunction

    logic [c3nf_pkg::KERNEL_BITS-1:0] all_neg;
    logic [c3nf_pkg::KERNEL_BITS-1:0] all_pos;

    initial
    begin
        rst_n <= 1'b0;
        pix.valid = 1'b0;
        pix.pixel_c0 = '0;
        pix.pixel_c1 = '0;
        pix.pixel_c2 = '0;
        pix.flush = 1'b0;
        res.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = c3nf_pkg::REG_KERNEL;
        cfg_data = '0;
        errors = 0;
        checked = 0;
        items_pushed = 0;
        frames_sent = 0;
        quiet = 0;
        idle_cycles = 0;
        kernel = c3nf_pkg::KERNEL_RESET;
        gray = 1'b0;
        width_reg = c3nf_pkg::WIDTH_RESET;
        height_reg = c3nf_pkg::HEIGHT_RESET;
        for (int i = 0; i < 2 * WIDTH_CAP; i++)
            line_mem[i] = '0;
        restart_frame();
        for (int i = 0; i < 9; i++)
        begin
            all_neg[c3nf_pkg::COEF_BITS*i +: c3nf_pkg::COEF_BITS] = 7'h40;
            all_pos[c3nf_pkg::COEF_BITS*i +: c3nf_pkg::COEF_BITS] = 7'h3F;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity kernel on a 3x3 frame with extreme samples
        write_reg(c3nf_pkg::REG_WIDTH, 63'd3);
        write_reg(c3nf_pkg::REG_HEIGHT, 63'd3);
        push_pixel(255, 255, 255, 1'b0);
        push_pixel(0, 0, 0, 1'b0);
        push_pixel(255, 0, 255, 1'b0);
        push_pixel(0, 255, 0, 1'b1);
        push_pixel(128, 127, 1, 1'b0);
        push_pixel(255, 255, 255, 1'b0);
        push_pixel(1, 254, 128, 1'b0);
        push_pixel(255, 255, 255, 1'b0);
        push_pixel(0, 0, 0, 1'b0);
        push_pixel(255, 255, 255, 1'b0);
        push_pixel(9, 9, 9, 1'b1);
        push_pixel(200, 100, 50, 1'b0);
        push_pixel(0, 0, 0, 1'b1);
        frames_sent++;
        wait_idle();
        // all-zero kernel, then an all-negative kernel in gray mode and an all-positive one in color mode
        write_reg(c3nf_pkg::REG_KERNEL, '0);
        push_frame(0);
        wait_idle();
        write_reg(c3nf_pkg::REG_KERNEL, all_neg);
        write_reg(c3nf_pkg::REG_COLOR, 63'd1);
        push_frame(0);
        wait_idle();
        write_reg(c3nf_pkg::REG_KERNEL, all_pos);
        write_reg(c3nf_pkg::REG_COLOR, 63'd0);
        push_frame(0);
        wait_idle();

        // clamped geometry: over-wide line, shortest frame, only its first items
        write_reg(c3nf_pkg::REG_COLOR, 63'd1);
        write_reg(c3nf_pkg::REG_KERNEL, random_kernel());
        write_reg(c3nf_pkg::REG_WIDTH, 63'd2047);
        write_reg(c3nf_pkg::REG_HEIGHT, 63'd0);
        push_frame(60);
        wait_idle();
        // tallest frame: only its top rows, then restart with a geometry write
        write_reg(c3nf_pkg::REG_WIDTH, 63'd2);
        write_reg(c3nf_pkg::REG_HEIGHT, 63'd2047);
        push_frame(40);
        wait_idle();
        write_reg(c3nf_pkg::REG_HEIGHT, 63'd1024);
        push_frame(25);
        wait_idle();

        // random phases
        while (items_pushed < 750)
        begin
            write_reg(c3nf_pkg::REG_WIDTH, ($urandom_range(0, 9) == 0) ?
                      63'($urandom_range(0, 2)) : 63'($urandom_range(3, 12)));
            write_reg(c3nf_pkg::REG_HEIGHT, ($urandom_range(0, 9) == 0) ?
                      63'($urandom_range(0, 2)) : 63'($urandom_range(3, 6)));
            if ($urandom_range(0, 1) == 0)
                write_reg(c3nf_pkg::REG_KERNEL, random_kernel());
            if ($urandom_range(0, 2) == 0)
                write_reg(c3nf_pkg::REG_COLOR, 63'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                push_frame($urandom_range(1, 20));
            else
                repeat ($urandom_range(1, 2)) push_frame(0);
            wait_idle();
        end

        // last stretch with no idling on either side
        quiet = 1;
        write_reg(c3nf_pkg::REG_COLOR, 63'd0);
        write_reg(c3nf_pkg::REG_KERNEL, random_kernel());
        write_reg(c3nf_pkg::REG_WIDTH, 63'd8);
        write_reg(c3nf_pkg::REG_HEIGHT, 63'd5);
        repeat (3) push_frame(0);
        wait_idle();

        $display("covered %0d pixel transactions in %0d frames, %0d results checked",
                 items_pushed, frames_sent, checked);
        $display("%0d field mismatches", errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
